// ===== sv/depth_pixel_backproject_transform_unit_assert.svh =====
// assertion macros shared by the back-projection unit's modules
// expects signals named clk and arst_n in the module that uses them
`ifndef DEPTH_PIXEL_BACKPROJECT_TRANSFORM_UNIT_ASSERT_SVH
`define DEPTH_PIXEL_BACKPROJECT_TRANSFORM_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DPBT_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dpbt assertion failed");

// next-cycle implication, checked outside reset
`define DPBT_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dpbt assertion failed");

`endif

// ===== sv/dpbt_pkg.sv =====
// shared types, constants and tables of the depth back-projection unit
// no dependencies
package dpbt_pkg;

	localparam int SAMPLE_STEP = 5;
	localparam int COORD_BITS  = 12;

	localparam int PIX_W   = 12;
	localparam int DEPTH_W = 16;
	localparam int Z_W     = 14;
	localparam int OUT_W   = 24;

	localparam logic [DEPTH_W-1:0] DEPTH_MIN_MM = 16'd10;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX_MM = 16'd10000;
	localparam logic [15:0] COORD_MASK = 16'((32'd1 << COORD_BITS) - 32'd1);

	// datapath widths
	localparam int U_W      = 18;
	localparam int UZ_W     = 31;
	localparam int P_W      = 56;
	localparam int XC_SHIFT = 28;
	localparam int XC_W     = 28;
	localparam int R_W      = 44;
	localparam int ACC_W    = 46;
	localparam int W_SHIFT  = 14;
	localparam int SUM_W    = 33;

	localparam logic signed [P_W-1:0]   X_ROUND = P_W'(64'sd1 <<< (XC_SHIFT - 1));
	localparam logic signed [ACC_W-1:0] W_ROUND = ACC_W'(64'sd1 <<< (W_SHIFT - 1));
	localparam logic signed [SUM_W-1:0] SAT_MAX = 33'sd8388607;
	localparam logic signed [SUM_W-1:0] SAT_MIN = -33'sd8388608;

	// config register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POSE_ROW_X  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_POSE_ROW_Y  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_POSE_ROW_Z  = 3'd6;

	localparam logic [23:0] INV_FOCAL_RESET = 24'd33554;
	localparam logic [15:0] CENTER_X_RESET  = 16'd5120;
	localparam logic [15:0] CENTER_Y_RESET  = 16'd3840;
	localparam logic [63:0] POSE_X_RESET    = 64'h0000_0000_0000_4000;
	localparam logic [63:0] POSE_Y_RESET    = 64'h0000_0000_4000_0000;
	localparam logic [63:0] POSE_Z_RESET    = 64'h0000_4000_0000_0000;

	// queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
	} color_t;

	typedef struct packed {
		logic [PIX_W-1:0] row;
		logic [PIX_W-1:0] col;
		logic [Z_W-1:0]   depth;
		color_t           color;
	} kept_item_t;

	typedef struct packed {
		logic [23:0]      inv_focal_x;
		logic [23:0]      inv_focal_y;
		logic [15:0]      center_x;
		logic [15:0]      center_y;
		logic [2:0][63:0] pose;
	} cam_cfg_t;

	// residue of each coordinate nibble at its weight, modulo the sample step
	typedef logic [3:0] res_t;
	typedef res_t [3:0][15:0] res_tab_t;

	function automatic res_tab_t make_res_tab();
		res_tab_t t;
		for (int k = 0; k < 4; k++) begin
			for (int c = 0; c < 16; c++) begin
				t[k][c] = 4'((c << (4 * k)) % SAMPLE_STEP);
			end
		end
		return t;
	endfunction

	// bit s set when s is a multiple of the sample step
	function automatic logic [63:0] make_zero_tab();
		logic [63:0] z;
		for (int s = 0; s < 64; s++) begin
			z[s] = ((s % SAMPLE_STEP) == 0);
		end
		return z;
	endfunction

	localparam res_tab_t    RES_TAB       = make_res_tab();
	localparam logic [63:0] STEP_ZERO_TAB = make_zero_tab();

endpackage

// ===== sv/dpbt_front.sv =====
// front end: accepts pixels, checks sampling grid and depth range
// depends on dpbt_pkg
module dpbt_front (
	input  logic                       push,
	output logic                       full,
	input  logic [11:0]                pixel_row,
	input  logic [11:0]                pixel_col,
	input  logic [15:0]                depth_mm,
	input  logic [7:0]                 color_byte0,
	input  logic [7:0]                 color_byte1,
	input  logic [7:0]                 color_byte2,
	input  logic                       q_full,
	output logic                       q_wr,
	output dpbt_pkg::kept_item_t       q_item
);
	import dpbt_pkg::*;

	logic [15:0] row_m;
	logic [15:0] col_m;
	logic        on_grid;
	logic        depth_ok;

	function automatic logic step_aligned(input logic [15:0] c);
		logic [5:0] s;
		s = 6'(RES_TAB[0][c[3:0]]) + 6'(RES_TAB[1][c[7:4]])
			+ 6'(RES_TAB[2][c[11:8]]) + 6'(RES_TAB[3][c[15:12]]);
		return STEP_ZERO_TAB[s];
	endfunction

	assign row_m    = 16'(pixel_row) & COORD_MASK;
	assign col_m    = 16'(pixel_col) & COORD_MASK;
	assign on_grid  = step_aligned(row_m) && step_aligned(col_m);
	assign depth_ok = (depth_mm >= DEPTH_MIN_MM) && (depth_mm <= DEPTH_MAX_MM);

	assign full = q_full;
	assign q_wr = push && !q_full && on_grid && depth_ok;

	always_comb begin
		q_item.row         = 12'(row_m);
		q_item.col         = 12'(col_m);
		q_item.depth       = Z_W'(depth_mm);
		q_item.color.byte0 = color_byte0;
		q_item.color.byte1 = color_byte1;
		q_item.color.byte2 = color_byte2;
	end

endmodule

// ===== sv/dpbt_fifo.sv =====
// short request queue between front and back
// depends on dpbt_pkg
`include "depth_pixel_backproject_transform_unit_assert.svh"
module dpbt_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  dpbt_pkg::kept_item_t wr_item,
	output logic                 full,
	input  logic                 rd_en,
	output dpbt_pkg::kept_item_t rd_item,
	output logic                 empty
);
	import dpbt_pkg::*;

	kept_item_t       slot_q [Q_DEPTH];
	logic [Q_AW-1:0]  wr_ptr_q;
	logic [Q_AW-1:0]  rd_ptr_q;
	logic [Q_CW-1:0]  count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == Q_CW'(Q_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`DPBT_ASSERT_NXT(a_q_grow, do_wr && !do_rd, count_q == $past(count_q) + 1'b1)
	`DPBT_ASSERT_NXT(a_q_idle, !do_wr && !do_rd, $stable(count_q) && $stable(rd_ptr_q))

endmodule

// ===== sv/dpbt_back.sv =====
// back end: seven-stage back-projection and pose transform pipeline
// depends on dpbt_pkg; the last stage is the result register
`include "depth_pixel_backproject_transform_unit_assert.svh"
module dpbt_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dpbt_pkg::cam_cfg_t   cfg,
	input  logic                 in_valid,
	input  dpbt_pkg::kept_item_t in_item,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 pop,
	output logic signed [23:0]   world_x,
	output logic signed [23:0]   world_y,
	output logic signed [23:0]   world_z,
	output logic [7:0]           blue,
	output logic [7:0]           green,
	output logic [7:0]           red
);
	import dpbt_pkg::*;

	logic [7:1] rdy;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;

	logic signed [U_W-1:0]   u_s1, v_s1;
	logic [Z_W-1:0]          z_s1, z_s2, z_s3;
	logic signed [UZ_W-1:0]  uz_s2, vz_s2;
	logic signed [P_W-1:0]   px_s3, py_s3;
	logic signed [XC_W-1:0]  xc_s4, yc_s4, zc_s4;
	logic signed [R_W-1:0]   prod_s5 [3][3];
	logic signed [ACC_W-1:0] acc_s6 [3];
	logic signed [OUT_W-1:0] world_s7 [3];
	color_t                  color_s1, color_s2, color_s3, color_s4;
	color_t                  color_s5, color_s6, color_s7;

	logic signed [P_W-1:0]   px_rnd, py_rnd;
	logic signed [XC_W-1:0]  cam [3];
	logic signed [SUM_W-1:0] wsum [3];

	function automatic logic signed [OUT_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
		if (v > SAT_MAX) begin
			return OUT_W'(SAT_MAX);
		end else if (v < SAT_MIN) begin
			return OUT_W'(SAT_MIN);
		end
		return OUT_W'(v);
	endfunction

	// a stage takes new data when empty or when its successor takes its data
	assign rdy[7] = !valid_s7 || pop;
	assign rdy[6] = !valid_s6 || rdy[7];
	assign rdy[5] = !valid_s5 || rdy[6];
	assign rdy[4] = !valid_s4 || rdy[5];
	assign rdy[3] = !valid_s3 || rdy[4];
	assign rdy[2] = !valid_s2 || rdy[3];
	assign rdy[1] = !valid_s1 || rdy[2];

	assign in_ready  = rdy[1];
	assign out_valid = valid_s7;

	assign px_rnd = px_s3 + X_ROUND;
	assign py_rnd = py_s3 + X_ROUND;

	always_comb begin
		cam[0] = xc_s4;
		cam[1] = yc_s4;
		cam[2] = zc_s4;
		for (int i = 0; i < 3; i++) begin
			wsum[i] = SUM_W'(acc_s6[i] >>> W_SHIFT) + SUM_W'($signed(cfg.pose[i][63:48]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (rdy[1]) valid_s1 <= in_valid;
			if (rdy[2]) valid_s2 <= valid_s1;
			if (rdy[3]) valid_s3 <= valid_s2;
			if (rdy[4]) valid_s4 <= valid_s3;
			if (rdy[5]) valid_s5 <= valid_s4;
			if (rdy[6]) valid_s6 <= valid_s5;
			if (rdy[7]) valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		// offsets from the principal point, 1/16 pixel
		if (rdy[1]) begin
			u_s1     <= $signed({2'b00, in_item.col, 4'b0000}) - $signed({2'b00, cfg.center_x});
			v_s1     <= $signed({2'b00, in_item.row, 4'b0000}) - $signed({2'b00, cfg.center_y});
			z_s1     <= in_item.depth;
			color_s1 <= in_item.color;
		end
		if (rdy[2]) begin
			uz_s2    <= UZ_W'(u_s1) * UZ_W'($signed({1'b0, z_s1}));
			vz_s2    <= UZ_W'(v_s1) * UZ_W'($signed({1'b0, z_s1}));
			z_s2     <= z_s1;
			color_s2 <= color_s1;
		end
		if (rdy[3]) begin
			px_s3    <= P_W'(uz_s2) * P_W'($signed({1'b0, cfg.inv_focal_x}));
			py_s3    <= P_W'(vz_s2) * P_W'($signed({1'b0, cfg.inv_focal_y}));
			z_s3     <= z_s2;
			color_s3 <= color_s2;
		end
		// camera coordinates in mm, rounded half up
		if (rdy[4]) begin
			xc_s4    <= XC_W'(px_rnd >>> XC_SHIFT);
			yc_s4    <= XC_W'(py_rnd >>> XC_SHIFT);
			zc_s4    <= XC_W'($signed({1'b0, z_s3}));
			color_s4 <= color_s3;
		end
		if (rdy[5]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s5[i][j] <= R_W'($signed(cfg.pose[i][16*j +: 16])) * R_W'(cam[j]);
				end
			end
			color_s5 <= color_s4;
		end
		if (rdy[6]) begin
			for (int i = 0; i < 3; i++) begin
				acc_s6[i] <= ACC_W'(prod_s5[i][0]) + ACC_W'(prod_s5[i][1])
					+ ACC_W'(prod_s5[i][2]) + W_ROUND;
			end
			color_s6 <= color_s5;
		end
		if (rdy[7]) begin
			for (int i = 0; i < 3; i++) begin
				world_s7[i] <= sat24(wsum[i]);
			end
			color_s7 <= color_s6;
		end
	end

	assign world_x = world_s7[0];
	assign world_y = world_s7[1];
	assign world_z = world_s7[2];
	assign blue    = color_s7.byte2;
	assign green   = color_s7.byte1;
	assign red     = color_s7.byte0;

	`DPBT_ASSERT_NXT(a_take_in, in_valid && in_ready, valid_s1)
	`DPBT_ASSERT_NXT(a_hold_out, valid_s7 && !pop, valid_s7 && $stable(world_s7[0]) && $stable(color_s7))
	`DPBT_ASSERT_NXT(a_drain, valid_s7 && pop && !valid_s6, !valid_s7)

endmodule

// ===== sv/depth_pixel_backproject_transform_unit.sv =====
// depth pixel back-projection unit: top level with configuration registers
// depends on dpbt_pkg, dpbt_front, dpbt_fifo and dpbt_back
//
// usage:
//  - pixel requests enter on push/full; a request is taken at a clock edge with
//    push high and full low. off-grid pixels and depths outside 10..10000 mm
//    are taken and dropped without a result
//  - results leave on empty/pop; the oldest point sits on the ports while
//    empty is low and is taken at an edge with pop high
//  - configuration is a plain write port (cfg_write, cfg_index, cfg_data);
//    write only while no request is in flight. unknown indexes are ignored
//  - throughput: one pixel per cycle while the receiver keeps popping; the seven-stage
//    back pipeline carries one request per stage
//  - a kept pixel is written into the queue at the edge that takes it, then runs through
//    back pipeline stages s1 to s7, and the last of them drives the result ports
//  - when the receiver stalls the pipeline holds its data; the four-entry
//    queue absorbs further pixels and full rises once it fills
//  - reset (arst_n low) empties queue and pipeline and loads default optics
//    and the identity pose
module depth_pixel_backproject_transform_unit (
	input  logic               clk,
	input  logic               arst_n,
	// pixel requests
	input  logic               push,
	output logic               full,
	input  logic [11:0]        pixel_row,
	input  logic [11:0]        pixel_col,
	input  logic [15:0]        depth_mm,
	input  logic [7:0]         color_byte0,
	input  logic [7:0]         color_byte1,
	input  logic [7:0]         color_byte2,
	// world points
	output logic               empty,
	input  logic               pop,
	output logic signed [23:0] world_x,
	output logic signed [23:0] world_y,
	output logic signed [23:0] world_z,
	output logic [7:0]         blue,
	output logic [7:0]         green,
	output logic [7:0]         red,
	// configuration
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data
);
	import dpbt_pkg::*;

	cam_cfg_t   cfg_q;
	logic       q_full;
	logic       q_wr;
	kept_item_t q_wr_item;
	logic       q_empty;
	logic       q_rd;
	kept_item_t q_rd_item;
	logic       back_valid;

	// configuration registers, written in place
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_focal_x <= INV_FOCAL_RESET;
			cfg_q.inv_focal_y <= INV_FOCAL_RESET;
			cfg_q.center_x    <= CENTER_X_RESET;
			cfg_q.center_y    <= CENTER_Y_RESET;
			cfg_q.pose[0]     <= POSE_X_RESET;
			cfg_q.pose[1]     <= POSE_Y_RESET;
			cfg_q.pose[2]     <= POSE_Z_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_INV_FOCAL_X: cfg_q.inv_focal_x <= cfg_data[23:0];
				REG_INV_FOCAL_Y: cfg_q.inv_focal_y <= cfg_data[23:0];
				REG_CENTER_X:    cfg_q.center_x    <= cfg_data[15:0];
				REG_CENTER_Y:    cfg_q.center_y    <= cfg_data[15:0];
				REG_POSE_ROW_X:  cfg_q.pose[0]     <= cfg_data;
				REG_POSE_ROW_Y:  cfg_q.pose[1]     <= cfg_data;
				REG_POSE_ROW_Z:  cfg_q.pose[2]     <= cfg_data;
				default: begin
					// index beyond the register list: ignored
				end
			endcase
		end
	end

	// front: classify and queue kept pixels
	dpbt_front u_front (
		.push        (push),
		.full        (full),
		.pixel_row   (pixel_row),
		.pixel_col   (pixel_col),
		.depth_mm    (depth_mm),
		.color_byte0 (color_byte0),
		.color_byte1 (color_byte1),
		.color_byte2 (color_byte2),
		.q_full      (q_full),
		.q_wr        (q_wr),
		.q_item      (q_wr_item)
	);

	// decoupling queue
	dpbt_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_item (q_wr_item),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_item (q_rd_item),
		.empty   (q_empty)
	);

	// back: projection, pose transform, result register
	dpbt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (!q_empty),
		.in_item   (q_rd_item),
		.in_ready  (q_rd),
		.out_valid (back_valid),
		.pop       (pop),
		.world_x   (world_x),
		.world_y   (world_y),
		.world_z   (world_z),
		.blue      (blue),
		.green     (green),
		.red       (red)
	);

	assign empty = !back_valid;

endmodule

// ===== dv/depth_point_checker.sv =====
`timescale 1ns / 100ps
// point checker for the depth pixel back-projection unit: mirrors the optics and pose
// registers, predicts the world point of every kept pixel request and compares it
// depends on dpbt_pkg
module depth_point_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic [11:0]        pixel_row,
	input  logic [11:0]        pixel_col,
	input  logic [15:0]        depth_mm,
	input  logic [7:0]         color_byte0,
	input  logic [7:0]         color_byte1,
	input  logic [7:0]         color_byte2,
	input  logic               empty,
	input  logic               pop,
	input  logic signed [23:0] world_x,
	input  logic signed [23:0] world_y,
	input  logic signed [23:0] world_z,
	input  logic [7:0]         blue,
	input  logic [7:0]         green,
	input  logic [7:0]         red,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	output int                 mismatches,
	output int                 points_pending
);
	import dpbt_pkg::*;

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
		logic [7:0]         blue;
		logic [7:0]         green;
		logic [7:0]         red;
	} world_point_t;

	logic [23:0] inv_fx, inv_fy;
	logic [15:0] cen_x, cen_y;
	logic [63:0] pose_x, pose_y, pose_z;
	world_point_t points_due[$];
	int mismatch_total = 0;

	initial begin
		mismatches = 0;
		points_pending = 0;
	end

	// round to nearest, ties up
	function automatic longint round_shr(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint world_coord(logic [63:0] r, longint x, longint y, longint z);
		longint acc;
		acc = longint'($signed(r[15:0])) * x + longint'($signed(r[31:16])) * y
			+ longint'($signed(r[47:32])) * z;
		acc = round_shr(acc, 14) + longint'($signed(r[63:48]));
		if (acc > 64'sd8388607)
			acc = 64'sd8388607;
		else if (acc < -64'sd8388608)
			acc = -64'sd8388608;
		return acc;
	endfunction

	// returns 0 for a dropped pixel
	function automatic bit backproject(input logic [11:0] row, input logic [11:0] col,
			input logic [15:0] depth, input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, output world_point_t pt);
		logic [11:0] r, c;
		longint z, u, v, xc, yc;
		pt = '0;
		r = row & COORD_MASK[11:0];
		c = col & COORD_MASK[11:0];
		if ((r % SAMPLE_STEP) != 0 || (c % SAMPLE_STEP) != 0)
			return 1'b0;
		if (depth < DEPTH_MIN_MM || depth > DEPTH_MAX_MM)
			return 1'b0;
		z = longint'(depth);
		u = longint'(c) * 16 - longint'(cen_x);
		v = longint'(r) * 16 - longint'(cen_y);
		xc = round_shr(u * z * longint'(inv_fx), 28);
		yc = round_shr(v * z * longint'(inv_fy), 28);
		pt.x = 24'(world_coord(pose_x, xc, yc, z));
		pt.y = 24'(world_coord(pose_y, xc, yc, z));
		pt.z = 24'(world_coord(pose_z, xc, yc, z));
		pt.blue = b2;
		pt.green = b1;
		pt.red = b0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_total++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		world_point_t pt, due;
		if (!arst_n) begin
			inv_fx = INV_FOCAL_RESET;
			inv_fy = INV_FOCAL_RESET;
			cen_x = CENTER_X_RESET;
			cen_y = CENTER_Y_RESET;
			pose_x = POSE_X_RESET;
			pose_y = POSE_Y_RESET;
			pose_z = POSE_Z_RESET;
			points_due.delete();
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_INV_FOCAL_X: inv_fx = cfg_data[23:0];
					REG_INV_FOCAL_Y: inv_fy = cfg_data[23:0];
					REG_CENTER_X:    cen_x = cfg_data[15:0];
					REG_CENTER_Y:    cen_y = cfg_data[15:0];
					REG_POSE_ROW_X:  pose_x = cfg_data;
					REG_POSE_ROW_Y:  pose_y = cfg_data;
					REG_POSE_ROW_Z:  pose_z = cfg_data;
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (points_due.size() == 0) begin
					report_mismatch($sformatf("point (%0d, %0d, %0d) with no pixel pending",
						world_x, world_y, world_z));
				end else begin
					due = points_due.pop_front();
					if (world_x !== due.x)
						report_mismatch($sformatf("world_x %0d, expected %0d", world_x, due.x));
					if (world_y !== due.y)
						report_mismatch($sformatf("world_y %0d, expected %0d", world_y, due.y));
					if (world_z !== due.z)
						report_mismatch($sformatf("world_z %0d, expected %0d", world_z, due.z));
					if (blue !== due.blue)
						report_mismatch($sformatf("blue %0d, expected %0d", blue, due.blue));
					if (green !== due.green)
						report_mismatch($sformatf("green %0d, expected %0d", green, due.green));
					if (red !== due.red)
						report_mismatch($sformatf("red %0d, expected %0d", red, due.red));
				end
			end
			if (push && !full) begin
				if (backproject(pixel_row, pixel_col, depth_mm, color_byte0, color_byte1,
						color_byte2, pt))
					points_due = {points_due, pt};
			end
		end
		mismatches <= mismatch_total;
		points_pending <= points_due.size();
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// top of the depth pixel back-projection testbench: clock, reset, pixel requests,
// register writes, result draining and the verdict
// depends on dpbt_pkg, depth_pixel_backproject_transform_unit and depth_point_checker
module testbench;
	import dpbt_pkg::*;

	// generous bound for ~560 requests plus drains
	localparam int CYCLE_LIMIT = 200000;
	// index past the last register, writes to it must be ignored
	localparam logic [2:0] REG_UNUSED = 3'd7;
	// cycles to wait after the last predicted point before a register write
	localparam int SETTLE_CYCLES = 12;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [11:0]        pixel_row = '0;
	logic [11:0]        pixel_col = '0;
	logic [15:0]        depth_mm = '0;
	logic [7:0]         color_byte0 = '0;
	logic [7:0]         color_byte1 = '0;
	logic [7:0]         color_byte2 = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic signed [23:0] world_x, world_y, world_z;
	logic [7:0]         blue, green, red;
	logic               cfg_write = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [63:0]        cfg_data = '0;

	int mismatches;
	int points_pending;

	// set for the last phase: no gaps on either side
	bit quiet_tail = 1'b0;
	int pop_hold = 0;
	int pop_calm = 0;

	depth_pixel_backproject_transform_unit dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.pixel_row(pixel_row), .pixel_col(pixel_col), .depth_mm(depth_mm),
		.color_byte0(color_byte0), .color_byte1(color_byte1), .color_byte2(color_byte2),
		.empty(empty), .pop(pop),
		.world_x(world_x), .world_y(world_y), .world_z(world_z),
		.blue(blue), .green(green), .red(red),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// watches both channels and the write port, predicts and compares
	depth_point_checker u_point_check (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.pixel_row(pixel_row), .pixel_col(pixel_col), .depth_mm(depth_mm),
		.color_byte0(color_byte0), .color_byte1(color_byte1), .color_byte2(color_byte2),
		.empty(empty), .pop(pop),
		.world_x(world_x), .world_y(world_y), .world_z(world_z),
		.blue(blue), .green(green), .red(red),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .points_pending(points_pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// hard stop in case a request or a point never gets through
	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAILURE");
		$finish;
	end

	// receiver side: mostly ready, with short stall bursts and now and then a
	// calm stretch; pop is updated once per falling edge
	always @(negedge clk) begin : pop_drive
		logic take;
		take = 1'b1;
		if (!quiet_tail) begin
			if (pop_calm > 0) begin
				pop_calm--;
			end else if (pop_hold > 0) begin
				take = 1'b0;
				pop_hold--;
			end else if ($urandom_range(0, 49) == 0) begin
				pop_calm = $urandom_range(20, 60);
			end else if ($urandom_range(0, 3) == 0) begin
				// stall starting now, extended by pop_hold
				take = 1'b0;
				pop_hold = $urandom_range(0, 3);
			end
		end
		pop <= take;
	end

	// one pixel request, with an optional idle gap ahead of it;
	// returns at the rising edge that takes it
	task automatic push_pixel(input logic [11:0] row, input logic [11:0] col,
			input logic [15:0] depth, input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2);
		int gap;
		gap = 0;
		if (!quiet_tail && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			@(negedge clk) push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		pixel_row <= row;
		pixel_col <= col;
		depth_mm <= depth;
		color_byte0 <= b0;
		color_byte1 <= b1;
		color_byte2 <= b2;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// mostly on-grid pixels with usable depth, some at the depth edges,
	// the rest anywhere at all
	task automatic random_pixel();
		logic [11:0] r, c;
		logic [15:0] d;
		int pick;
		pick = $urandom_range(0, 9);
		r = 12'(5 * $urandom_range(0, 819));
		c = 12'(5 * $urandom_range(0, 819));
		d = 16'($urandom_range(10, 10000));
		if (pick == 7) begin
			case ($urandom_range(0, 5))
				0: d = 16'd0;
				1: d = 16'd9;
				2: d = 16'd10;
				3: d = 16'd10000;
				4: d = 16'd10001;
				default: d = 16'hFFFF;
			endcase
		end else if (pick > 7) begin
			r = 12'($urandom);
			c = 12'($urandom);
			d = 16'($urandom);
		end
		push_pixel(r, c, d, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk) cfg_write <= 1'b0;
	endtask

	// stop requests, wait for every predicted point, then wait out the
	// settle time before going on
	task automatic drain();
		@(negedge clk) push <= 1'b0;
		while (points_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// all seven registers plus one write to the unused index
	task automatic load_config(input logic [63:0] ifx, input logic [63:0] ify,
			input logic [63:0] cx, input logic [63:0] cy, input logic [63:0] px,
			input logic [63:0] py, input logic [63:0] pz);
		drain();
		write_reg(REG_INV_FOCAL_X, ifx);
		write_reg(REG_INV_FOCAL_Y, ify);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_POSE_ROW_X, px);
		write_reg(REG_POSE_ROW_Y, py);
		write_reg(REG_POSE_ROW_Z, pz);
		write_reg(REG_UNUSED, {$urandom, $urandom});
	endtask

	// rotation terms within +-1.0 and any translation
	function automatic logic [63:0] near_pose();
		logic [15:0] t, a, b, c;
		a = 16'($urandom_range(0, 32768) - 16384);
		b = 16'($urandom_range(0, 32768) - 16384);
		c = 16'($urandom_range(0, 32768) - 16384);
		t = 16'($urandom);
		return {t, c, b, a};
	endfunction

	// camera-like optics, or every bit random including unused upper bits
	task automatic random_config(input bit camera_like);
		if (camera_like)
			load_config(64'($urandom_range(8389, 83886)), 64'($urandom_range(8389, 83886)),
				64'($urandom_range(0, 65520)), 64'($urandom_range(0, 65520)),
				near_pose(), near_pose(), near_pose());
		else
			load_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom});
	endtask

	initial begin : stimulus
		// reset held from the start, released on a falling edge
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed requests under the default optics and identity pose
		push_pixel(12'd0, 12'd0, 16'd10, 8'h00, 8'h00, 8'h00);
		push_pixel(12'd4095, 12'd4095, 16'd10000, 8'hFF, 8'hFF, 8'hFF);
		push_pixel(12'd0, 12'd4095, 16'd10000, 8'hAA, 8'h55, 8'h0F);
		push_pixel(12'd4095, 12'd0, 16'd10, 8'h01, 8'h80, 8'hFE);
		// principal point: camera x and y come out zero
		push_pixel(12'd240, 12'd320, 16'd1000, 8'h12, 8'h34, 8'h56);
		// depth just outside the range, no reading, and all ones
		push_pixel(12'd5, 12'd5, 16'd9, 8'h11, 8'h22, 8'h33);
		push_pixel(12'd5, 12'd5, 16'd10001, 8'h11, 8'h22, 8'h33);
		push_pixel(12'd5, 12'd5, 16'd0, 8'h11, 8'h22, 8'h33);
		push_pixel(12'd5, 12'd5, 16'hFFFF, 8'h11, 8'h22, 8'h33);
		// off-grid row, off-grid column, both off-grid
		push_pixel(12'd1, 12'd5, 16'd500, 8'h44, 8'h55, 8'h66);
		push_pixel(12'd5, 12'd4094, 16'd500, 8'h44, 8'h55, 8'h66);
		push_pixel(12'd4094, 12'd4094, 16'd500, 8'h44, 8'h55, 8'h66);
		push_pixel(12'd2730, 12'd1365, 16'd5000, 8'h5A, 8'hA5, 8'hC3);
		push_pixel(12'd5, 12'd10, 16'd11, 8'h7F, 8'h80, 8'h00);

		// largest reciprocals, centre at zero, saturating poses
		load_config(64'hFFFFFF, 64'hFFFFFF, 64'h0, 64'h0,
			{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
			{16'h8000, 16'h8000, 16'h8000, 16'h8000},
			{16'h8000, 16'h0000, 16'h4000, 16'h7FFF});
		push_pixel(12'd4095, 12'd4095, 16'd10000, 8'hFF, 8'h00, 8'hFF);
		push_pixel(12'd0, 12'd0, 16'd10, 8'h00, 8'hFF, 8'h00);
		repeat (65) random_pixel();

		// zero reciprocals: camera x and y are zero whatever the offset
		load_config(64'h0, 64'h0, 64'hFFFF, 64'hFFFF,
			POSE_X_RESET | {16'h8000, 48'h0}, POSE_Y_RESET | {16'h7FFF, 48'h0},
			POSE_Z_RESET);
		push_pixel(12'd0, 12'd0, 16'd10000, 8'h0F, 8'hF0, 8'h3C);
		repeat (45) random_pixel();

		// one realistic and one fully random setting in turn
		for (int phase = 0; phase < 6; phase++) begin
			random_config(phase[0] == 1'b0);
			if (phase == 5)
				quiet_tail = 1'b1;
			repeat (72) random_pixel();
		end

		drain();
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
